>>> design/double_ended_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit
// Clocked property checks with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DQU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DQU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQU_ASSERT(lbl, prop, msg)
`define DQU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/dqu_pkg.sv
// ----------------------------------------------------------------------------
// dqu_pkg
// Sizes, action and status codes and ring index helper for the deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int SUM_W     = IDX_W + 2;
	localparam int DATA_W    = 32;
	localparam int ACT_W     = 3;
	localparam int CNT_OUT_W = 5;
	localparam int STAT_W    = 2;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 72;

	localparam logic [ACT_W-1:0] ACT_PEEK       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [DATA_W-1:0] EMPTY_READ = '1;

	// (h + off) mod DEPTH, with h < DEPTH and off <= DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(h) + SUM_W'(off);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> design/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed 32-bit values kept in a ring memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per transfer: action (peek, push back, push
//   front, pop back, pop front) and the value to push. m_* returns one
//   result per request: front value, back value, count after the action and
//   a status (ok, pop on empty ignored, push on full dropped). Front and
//   back read all ones when the deque is empty.
//   A request passes the memory read stage and then the output register
//   before m_tvalid rises. A new request is taken every cycle while the
//   receiver does not stall; head and count registers are updated at the
//   request transfer, the ring memory is written and read in that same
//   cycle, and a write hitting a read address is forwarded.
//   When the receiver stalls, the result waits in the output register and
//   one more request can sit in the memory read stage; s_tready then drops.
//   Reset clears head, count and all valid flags; the ring content is
//   undefined until pushed and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit
	import dqu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // action[2:0], value[34:3]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // front[31:0], back[63:32],
	                                         // count[68:64], status[70:69]
);

	logic [DATA_W-1:0] mem [DEPTH];

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;

	logic [ACT_W-1:0]  in_act;
	logic [DATA_W-1:0] in_val;
	logic              acc;

	logic [IDX_W-1:0]  head_nx;
	logic [CNT_W-1:0]  count_nx;
	logic [STAT_W-1:0] stat_nx;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  front_a;
	logic [IDX_W-1:0]  back_a;

	logic              valid_s1;
	logic              empty_s1;
	logic              fwdf_s1;
	logic              fwdb_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [CNT_W-1:0]  count_s1;
	logic [STAT_W-1:0] stat_s1;
	logic [DATA_W-1:0] rdf_s1;
	logic [DATA_W-1:0] rdb_s1;
	logic              go_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] back_q;
	logic [CNT_W-1:0]  count_out_q;
	logic [STAT_W-1:0] stat_q;

	assign in_act   = s_tdata[ACT_W-1:0];
	assign in_val   = s_tdata[ACT_W+DATA_W-1:ACT_W];
	assign go_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		head_nx  = head_q;
		count_nx = count_q;
		stat_nx  = ST_OK;
		we       = 1'b0;
		waddr    = ring_add(head_q, count_q);
		case (in_act)
			ACT_PUSH_BACK: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					stat_nx = ST_FULL;
				end else begin
					we       = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			ACT_PUSH_FRONT: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					stat_nx = ST_FULL;
				end else begin
					head_nx  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
					waddr    = head_nx;
					we       = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (count_q == '0) begin
					stat_nx = ST_EMPTY;
				end else begin
					count_nx = count_q - 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (count_q == '0) begin
					stat_nx = ST_EMPTY;
				end else begin
					head_nx  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_nx = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		front_a = head_nx;
		back_a  = ring_add(head_nx, (count_nx == '0) ? '0 : count_nx - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (acc) begin
			head_q  <= head_nx;
			count_q <= count_nx;
		end
	end

	// ring memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (acc) begin
			rdf_s1 <= mem[front_a];
			rdb_s1 <= mem[back_a];
			if (we) begin
				mem[waddr] <= in_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			empty_s1 <= (count_nx == '0);
			fwdf_s1  <= we && (waddr == front_a);
			fwdb_s1  <= we && (waddr == back_a);
			wdata_s1 <= in_val;
			count_s1 <= count_nx;
			stat_s1  <= stat_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			front_q     <= empty_s1 ? EMPTY_READ : (fwdf_s1 ? wdata_s1 : rdf_s1);
			back_q      <= empty_s1 ? EMPTY_READ : (fwdb_s1 ? wdata_s1 : rdb_s1);
			count_out_q <= count_s1;
			stat_q      <= stat_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, stat_q, CNT_OUT_W'(count_out_q), back_q, front_q};

	`DQU_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`DQU_ASSERT(a_accept_loads_s1, acc |=> valid_s1, "accepted request lost")
	`DQU_ASSERT(a_full_count, (m_tvalid && stat_q == ST_FULL) |-> (count_out_q == CNT_W'(DEPTH)), "full status with room left")
	`DQU_ASSERT(a_empty_read, (m_tvalid && count_out_q == '0) |-> (front_q == EMPTY_READ && back_q == EMPTY_READ), "empty deque read not all ones")

endmodule

`default_nettype wire
